/* hw/rtl/lbss_pkg.sv */
package lbss_pkg;

    // table geometry (table length is a power of two)
    localparam int TABLE_LEN       = 512;
    localparam int LEVEL_FRAC_BITS = 16;

    localparam int IDX_W   = $clog2(TABLE_LEN);
    localparam int HALF    = TABLE_LEN / 2;
    localparam int QUARTER = TABLE_LEN / 4;
    localparam int QTR_W   = $clog2(QUARTER + 1);

    localparam int LEVEL_W = LEVEL_FRAC_BITS + 1;
    localparam int CH_W    = 8;
    localparam int COLOR_W = 3 * CH_W;
    localparam int STEP_W  = 9;
    localparam int SUM_W   = ((IDX_W > STEP_W) ? IDX_W : STEP_W) + 1;
    localparam int ZONES   = 4;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ZONE0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZONE1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZONE2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZONE3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP  = 3'd4;

    localparam logic [STEP_W-1:0]  STEP_RESET = 9'd1;

    typedef logic [LEVEL_W-1:0] level_t;
    typedef level_t quarter_tbl_t [QUARTER+1];

    // fixed point sine constants, q30
    localparam logic [63:0] Q30_ONE = 64'd1 << 30;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] HORNER_DIV [6] = '{64'd156, 64'd110, 64'd72,
                                               64'd42, 64'd20, 64'd6};
    localparam logic [63:0] LEVEL_FLOOR =
        (64'd36 * (64'd1 << LEVEL_FRAC_BITS) + 64'd50) / 64'd100;

    // one brightness entry for a reduced quarter-wave index
    function automatic level_t level_entry(input int unsigned m, input logic neg);
        logic [63:0] p;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] u;
        logic [63:0] lvl;
        int i;
        p  = (64'(m) << 32) / TABLE_LEN;
        x  = (p * PI_Q30) >> 31;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        for (i = 0; i < 6; i++)
        begin
            t = Q30_ONE - ((x2 * t) >> 30) / HORNER_DIV[i];
        end
        s = (x * t) >> 30;
        if (s > Q30_ONE)
        begin
            s = Q30_ONE;
        end
        u   = neg ? (Q30_ONE - s) : (Q30_ONE + s);
        lvl = (u + (64'd1 << (30 - LEVEL_FRAC_BITS))) >> (31 - LEVEL_FRAC_BITS);
        if (lvl < LEVEL_FLOOR)
        begin
            lvl = LEVEL_FLOOR;
        end
        return lvl[LEVEL_W-1:0];
    endfunction

    function automatic quarter_tbl_t build_quarter(input logic neg);
        quarter_tbl_t tbl;
        int m;
        for (m = 0; m <= QUARTER; m++)
        begin
            tbl[m] = level_entry(m, neg);
        end
        return tbl;
    endfunction

    // positive half and negative half of the wave, quarter-folded
    localparam quarter_tbl_t LEVEL_POS = build_quarter(1'b0);
    localparam quarter_tbl_t LEVEL_NEG = build_quarter(1'b1);

endpackage

/* hw/rtl/lbss_level_rom.sv */
module lbss_level_rom
    import lbss_pkg::*;
(
    input  logic [IDX_W-1:0] phase,
    output level_t           level
);

    logic                neg;
    logic [IDX_W-2:0]    half_idx;
    logic [IDX_W-1:0]    mirror;
    logic [QTR_W-1:0]    qtr_idx;

    // fold the full-wave index onto one quarter plus a sign
    always_comb
    begin
        neg      = phase[IDX_W-1];
        half_idx = phase[IDX_W-2:0];
        mirror   = IDX_W'(HALF) - IDX_W'(half_idx);
        if (IDX_W'(half_idx) > IDX_W'(QUARTER))
        begin
            qtr_idx = mirror[QTR_W-1:0];
        end
        else
        begin
            qtr_idx = QTR_W'(half_idx);
        end
        level = neg ? LEVEL_NEG[qtr_idx] : LEVEL_POS[qtr_idx];
    end

endmodule

/* hw/rtl/lbss_zone_scale.sv */
module lbss_zone_scale
    import lbss_pkg::*;
(
    input  logic [COLOR_W-1:0] color,
    input  level_t             level,
    output logic [COLOR_W-1:0] scaled
);

    localparam int PROD_W = CH_W + LEVEL_W;

    // per channel: (channel * level) >> frac bits, never above full scale
    for (genvar c = 0; c < 3; c++)
    begin : g_chan
        logic [PROD_W-1:0] prod;
        assign prod = PROD_W'(color[c*CH_W +: CH_W]) * PROD_W'(level);
        assign scaled[c*CH_W +: CH_W] = prod[LEVEL_FRAC_BITS +: CH_W];
    end

endmodule

/* hw/rtl/led_breathing_sine_scaler.sv */
// channel  | handshake            | payload
// ---------+----------------------+-------------------------------------------
// in       | in_valid / in_ready  | tick
// out      | out_valid / out_ready| zone0_scaled..zone3_scaled, level
// cfg      | cfg_we (no wait)     | cfg_index, cfg_data
//
// two register stages: the table lookup lands in the level register, the
// zone multiplies land in the output register; one transfer per cycle
// sustained while out_ready stays high, out_valid rising once a transfer
// has passed both registers; reset zeroes the phase and colors, sets the
// step to one and clears both valid flags
// a stalled output holds its data; the level stage keeps taking a transfer
// whenever the output stage can move on, so only a full pipe stalls input
module led_breathing_sine_scaler
    import lbss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 tick,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [COLOR_W-1:0]   zone0_scaled,
    output logic [COLOR_W-1:0]   zone1_scaled,
    output logic [COLOR_W-1:0]   zone2_scaled,
    output logic [COLOR_W-1:0]   zone3_scaled,
    output logic [LEVEL_W-1:0]   level,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COLOR_W-1:0]   cfg_data
);

    // configuration
    logic [COLOR_W-1:0] zone_color_reg [ZONES];
    logic [STEP_W-1:0]  phase_step_reg;

    // phase accumulator
    logic [IDX_W-1:0]   phase_index_reg;
    logic [IDX_W-1:0]   phase_index_next;
    logic [SUM_W-1:0]   phase_sum;

    // level stage
    logic               s1_valid_reg;
    level_t             lvl_reg;
    level_t             lut_level;

    // output stage
    logic               out_valid_reg;
    logic [COLOR_W-1:0] scaled_reg [ZONES];
    logic [COLOR_W-1:0] scaled_next [ZONES];
    level_t             level_out_reg;

    logic               s2_load;
    logic               in_xfer;

    // pipeline flow control
    assign s2_load  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s2_load;
    assign in_xfer  = in_valid && in_ready;

    // config writes, ignored beyond the last register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int z = 0; z < ZONES; z++)
            begin
                zone_color_reg[z] <= '0;
            end
            phase_step_reg <= STEP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ZONE0: zone_color_reg[0] <= cfg_data;
                CFG_ZONE1: zone_color_reg[1] <= cfg_data;
                CFG_ZONE2: zone_color_reg[2] <= cfg_data;
                CFG_ZONE3: zone_color_reg[3] <= cfg_data;
                CFG_STEP:  phase_step_reg    <= cfg_data[STEP_W-1:0];
                default:   ;
            endcase
        end
    end

    // phase advances modulo the table length on a tick transfer
    assign phase_sum        = SUM_W'(phase_index_reg) + SUM_W'(phase_step_reg);
    assign phase_index_next = phase_sum[IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_index_reg <= '0;
        end
        else if (in_xfer && tick)
        begin
            phase_index_reg <= phase_index_next;
        end
    end

    // level lookup at the phase before the advance
    lbss_level_rom u_level_rom
    (
        .phase (phase_index_reg),
        .level (lut_level)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            lvl_reg <= lut_level;
        end
    end

    // scale the four zones by the registered level
    for (genvar z = 0; z < ZONES; z++)
    begin : g_zone
        lbss_zone_scale u_zone_scale
        (
            .color  (zone_color_reg[z]),
            .level  (lvl_reg),
            .scaled (scaled_next[z])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_load)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load && s1_valid_reg)
        begin
            for (int z = 0; z < ZONES; z++)
            begin
                scaled_reg[z] <= scaled_next[z];
            end
            level_out_reg <= lvl_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign zone0_scaled = scaled_reg[0];
    assign zone1_scaled = scaled_reg[1];
    assign zone2_scaled = scaled_reg[2];
    assign zone3_scaled = scaled_reg[3];
    assign level        = level_out_reg;

endmodule

/* tb/sv/sine_dimmer_checker.sv */
`timescale 1ns / 100ps

module sine_dimmer_checker
    import lbss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 tick,

    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [COLOR_W-1:0]   zone0_scaled,
    input  logic [COLOR_W-1:0]   zone1_scaled,
    input  logic [COLOR_W-1:0]   zone2_scaled,
    input  logic [COLOR_W-1:0]   zone3_scaled,
    input  logic [LEVEL_W-1:0]   level,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COLOR_W-1:0]   cfg_data,

    output int                   fail_count,
    output int                   outstanding
);

    localparam logic [63:0] UNIT_Q30  = 64'd1 << 30;
    localparam logic [63:0] HALF_TURN = 64'd1 << 31;
    localparam logic [63:0] PI_IN_Q30 = 64'd3373259426;
    localparam logic [63:0] DIM_FLOOR =
        (64'd36 * (64'd1 << LEVEL_FRAC_BITS) + 64'd50) / 64'd100;
    localparam int SERIES_TERMS = 6;
    localparam logic [63:0] SERIES_DIV [SERIES_TERMS] = '{64'd156, 64'd110, 64'd72,
                                                          64'd42, 64'd20, 64'd6};
    localparam logic [31:0] CH_MAX = (32'd1 << CH_W) - 32'd1;

    typedef struct packed {
        logic [ZONES-1:0][COLOR_W-1:0] zone;
        level_t                        lvl;
    } dimmed_frame_t;

    dimmed_frame_t      expected_frames [$];
    logic [COLOR_W-1:0] base_color [ZONES];
    logic [STEP_W-1:0]  step_size;
    logic [IDX_W-1:0]   phase;
    int                 mismatches = 0;

    // brightness for a table position: folded sine series, offset and floored
    function automatic level_t breath_level(input logic [IDX_W-1:0] idx);
        logic [63:0] turn;
        logic [63:0] ang;
        logic [63:0] ang_sq;
        logic [63:0] poly;
        logic [63:0] sine;
        logic [63:0] biased;
        logic [63:0] raw;
        logic        trough;
        turn   = (64'(idx) << 32) / 64'(TABLE_LEN);
        trough = (turn >= HALF_TURN);
        if (trough)
        begin
            turn = turn - HALF_TURN;
        end
        if (turn > UNIT_Q30)
        begin
            turn = HALF_TURN - turn;
        end
        ang    = (turn * PI_IN_Q30) >> 31;
        ang_sq = (ang * ang) >> 30;
        poly   = UNIT_Q30;
        for (int i = 0; i < SERIES_TERMS; i++)
        begin
            poly = UNIT_Q30 - ((ang_sq * poly) >> 30) / SERIES_DIV[i];
        end
        sine = (ang * poly) >> 30;
        if (sine > UNIT_Q30)
        begin
            sine = UNIT_Q30;
        end
        biased = trough ? (UNIT_Q30 - sine) : (UNIT_Q30 + sine);
        raw    = (biased + (64'd1 << (30 - LEVEL_FRAC_BITS))) >> (31 - LEVEL_FRAC_BITS);
        if (raw < DIM_FLOOR)
        begin
            raw = DIM_FLOOR;
        end
        return level_t'(raw);
    endfunction

    // each 8-bit channel times the level, truncated and clamped
    function automatic logic [COLOR_W-1:0] dim_color(input logic [COLOR_W-1:0] color,
                                                     input level_t lvl);
        logic [COLOR_W-1:0] result;
        logic [31:0]        prod;
        result = '0;
        for (int c = 0; c < 3; c++)
        begin
            prod = (32'(color[c*CH_W +: CH_W]) * 32'(lvl)) >> LEVEL_FRAC_BITS;
            if (prod > CH_MAX)
            begin
                prod = CH_MAX;
            end
            result[c*CH_W +: CH_W] = prod[CH_W-1:0];
        end
        return result;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        dimmed_frame_t exp_frame;
        dimmed_frame_t new_frame;
        if (!rst_n)
        begin
            expected_frames.delete();
            for (int z = 0; z < ZONES; z++)
            begin
                base_color[z] = '0;
            end
            step_size   = STEP_RESET;
            phase       = '0;
            fail_count  <= mismatches;
            outstanding <= 0;
        end
        else
        begin
            // result side first: a result never belongs to a transfer taken this edge
            if (out_valid && out_ready)
            begin
                if (expected_frames.size() == 0)
                begin
                    $error("output transfer with no result expected");
                    mismatches++;
                end
                else
                begin
                    exp_frame = expected_frames.pop_front();
                    check_field("zone0_scaled", 32'(exp_frame.zone[0]), 32'(zone0_scaled));
                    check_field("zone1_scaled", 32'(exp_frame.zone[1]), 32'(zone1_scaled));
                    check_field("zone2_scaled", 32'(exp_frame.zone[2]), 32'(zone2_scaled));
                    check_field("zone3_scaled", 32'(exp_frame.zone[3]), 32'(zone3_scaled));
                    check_field("level", 32'(exp_frame.lvl), 32'(level));
                end
            end

            if (cfg_we)
            begin
                case (cfg_index) inside
                    CFG_ZONE0, CFG_ZONE1, CFG_ZONE2, CFG_ZONE3:
                        base_color[2'(cfg_index - CFG_ZONE0)] = cfg_data;
                    CFG_STEP:
                        step_size = cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end

            if (in_valid && in_ready)
            begin
                new_frame.lvl = breath_level(phase);
                for (int z = 0; z < ZONES; z++)
                begin
                    new_frame.zone[z] = dim_color(base_color[z], new_frame.lvl);
                end
                expected_frames.push_back(new_frame);
                if (tick)
                begin
                    phase = IDX_W'((SUM_W'(phase) + SUM_W'(step_size)) % TABLE_LEN);
                end
            end

            fail_count  <= mismatches;
            outstanding <= expected_frames.size();
        end
    end

endmodule

/* tb/sv/tb_led_breathing_sine_scaler.sv */
`timescale 1ns / 100ps

module tb_led_breathing_sine_scaler;
    import lbss_pkg::*;

    localparam int     RANDOM_PHASES   = 11;
    localparam int     ITEMS_PER_PHASE = 60;
    localparam int     MAX_GAP         = 13;
    // pipeline is two stages deep; a few spare cycles before touching registers
    localparam int     SETTLE_CYCLES   = 8;
    localparam int     MODE_SPAN       = 32;
    localparam longint TIMEOUT_NS      = 2_000_000;

    logic                 clk = 1'b0;
    logic                 rst_n;

    logic                 in_valid;
    logic                 in_ready;
    logic                 tick;

    logic                 out_valid;
    logic                 out_ready;
    logic [COLOR_W-1:0]   zone0_scaled;
    logic [COLOR_W-1:0]   zone1_scaled;
    logic [COLOR_W-1:0]   zone2_scaled;
    logic [COLOR_W-1:0]   zone3_scaled;
    logic [LEVEL_W-1:0]   level;

    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COLOR_W-1:0]   cfg_data;

    int                   errors;
    int                   pending;

    // when set, that side runs back to back with no idle cycles
    bit                   in_eager;
    bit                   out_eager;

    // 4 ns period, high then low
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    led_breathing_sine_scaler uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .tick         (tick),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .zone0_scaled (zone0_scaled),
        .zone1_scaled (zone1_scaled),
        .zone2_scaled (zone2_scaled),
        .zone3_scaled (zone3_scaled),
        .level        (level),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // watches all three channels, predicts every result and compares
    sine_dimmer_checker u_dimmer_chk
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .tick         (tick),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .zone0_scaled (zone0_scaled),
        .zone1_scaled (zone1_scaled),
        .zone2_scaled (zone2_scaled),
        .zone3_scaled (zone3_scaled),
        .level        (level),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (errors),
        .outstanding  (pending)
    );

    // one input transfer: optional idle gap, then hold valid until in_ready
    // called and returns at a falling edge; valid stays high on return so a
    // zero gap gives back-to-back transfers without a dropout
    task automatic send_tick(input logic t);
        int gap;
        gap = in_eager ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap)
            begin
                // tick is a don't care while idle, so toggle it as noise
                tick = 1'($urandom);
                @(negedge clk);
            end
        end
        in_valid = 1'b1;
        tick     = t;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // stop sending and wait for every predicted result to come back
    task automatic drain();
        in_valid = 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // registers only change with the pipe empty; optional writes to the
    // unused indexes, which must have no effect
    task automatic load_config(input logic [ZONES-1:0][COLOR_W-1:0] colors,
                               input logic [STEP_W-1:0] step_v,
                               input bit junk);
        drain();
        cfg_we = 1'b1;
        for (int z = 0; z < ZONES; z++)
        begin
            cfg_index = CFG_ZONE0 + CFG_IDX_W'(z);
            cfg_data  = colors[z];
            @(negedge clk);
        end
        // upper data bits are random: only the low step bits may matter
        cfg_index = CFG_STEP;
        cfg_data  = {(COLOR_W-STEP_W)'($urandom), step_v};
        @(negedge clk);
        if (junk)
        begin
            for (int j = int'(CFG_STEP) + 1; j < (1 << CFG_IDX_W); j++)
            begin
                cfg_index = CFG_IDX_W'(j);
                cfg_data  = COLOR_W'($urandom);
                @(negedge clk);
            end
        end
        cfg_we = 1'b0;
    endtask

    // result side: random stall before each transfer, with eager stretches
    initial
    begin
        int stall;
        int served;
        out_ready = 1'b0;
        out_eager = 1'b0;
        served    = 0;
        @(posedge rst_n);
        forever
        begin
            if (served % MODE_SPAN == 0)
            begin
                out_eager = ($urandom_range(0, 3) == 0);
            end
            stall = out_eager ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
            served++;
        end
    end

    // stimulus and verdict
    initial
    begin
        logic [ZONES-1:0][COLOR_W-1:0] colors;
        logic [STEP_W-1:0]             step_v;
        int                            sent;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        tick      = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_ZONE0;
        cfg_data  = '0;
        in_eager  = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset colors are black, step one: tick low must hold the phase
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);

        // step of a quarter minus two brings the phase to the crest
        load_config({24'hFEFEFE, 24'h010101, 24'h000000, 24'hFFFFFF},
                    STEP_W'(QUARTER - 2), 1'b1);
        send_tick(1'b1);

        // quarter step: crest, zero crossing, trough at the floor, wrap to 0
        load_config({24'h7F0180, 24'h01FE80, 24'h000000, 24'hFFFFFF},
                    STEP_W'(QUARTER), 1'b0);
        send_tick(1'b0);
        repeat (4) send_tick(1'b1);

        // zero step: level frozen
        load_config({24'h800000, 24'hFFFFFF, 24'hABCDEF, 24'h123456}, '0, 1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);

        // largest step: walks backwards one entry per tick from the crest
        load_config({24'hFFFFFF, 24'hFF0000, 24'h0000FF, 24'h00FF00}, '1, 1'b0);
        repeat (4) send_tick(1'b1);

        // random phases; every register reload is also a full drain of the pipe
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            for (int z = 0; z < ZONES; z++)
            begin
                case ($urandom_range(0, 7))
                    0:       colors[z] = '0;
                    1:       colors[z] = '1;
                    default: colors[z] = COLOR_W'($urandom);
                endcase
            end
            case ($urandom_range(0, 5))
                0:       step_v = '0;
                1:       step_v = '1;
                2:       step_v = STEP_RESET;
                default: step_v = STEP_W'($urandom);
            endcase
            load_config(colors, step_v, ($urandom_range(0, 2) == 0));

            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                if (sent % MODE_SPAN == 0)
                begin
                    in_eager = ($urandom_range(0, 3) == 0);
                end
                // mostly advancing ticks, some holds
                send_tick($urandom_range(0, 4) != 0);
                sent++;
            end
        end

        in_valid = 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        // catch any stray result after the last one expected
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (errors == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // hard stop if a handshake hangs
    initial
    begin
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
